/* design/two_key_sorted_priority_queue_defines.svh */
// Assertion macros for the two-key sorted priority queue.
// No dependencies; included by the modules that carry assertions.
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define TSKPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define TSKPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tskpq_pkg.sv */
// Package for the two-key sorted priority queue: field widths, codes,
// entry and payload types. No dependencies.
package tskpq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRI_BITS      = 8;
  localparam int TRT_BITS      = 16;
  localparam int TAG_BITS      = 16;
  localparam int OCC_BITS      = 5;

  // request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [PRI_BITS-1:0] pri;
    logic [TRT_BITS-1:0] trt;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } slot_ctl_t;

  typedef struct packed {
    logic                req_type;
    logic [PRI_BITS-1:0] entry_priority;
    logic [TRT_BITS-1:0] entry_treatment;
    logic [TAG_BITS-1:0] entry_id;
  } in_req_t;

  typedef struct packed {
    logic                head_valid;
    logic [PRI_BITS-1:0] head_priority;
    logic [TRT_BITS-1:0] head_treatment;
    logic [TAG_BITS-1:0] head_id;
    logic [OCC_BITS-1:0] occupancy;
    logic [1:0]          status;
  } out_rsp_t;

endpackage

/* design/tskpq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it with the
// pushed key, and shifts toward or away from the head. Uses tskpq_pkg.
module tskpq_cell import tskpq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  slot_ctl_t        ctl,
  input  logic [CNT_W-1:0] count,
  input  entry_t           new_entry,
  input  entry_t           prev_entry,
  input  logic             prev_shift,
  input  entry_t           next_entry,
  output entry_t           entry,
  output logic             shift
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  // an empty slot counts as larger than any key
  assign occupied = CNT_W'(IDX) < count;
  assign shift    = !occupied ||
                    ({entry_r.pri, entry_r.trt} > {new_entry.pri, new_entry.trt});

  // push: the first shifting slot takes the new entry, later ones take the
  // left neighbor; pop: every slot takes the right neighbor, the last slot keeps its own
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push && shift) begin
      entry_nxt = prev_shift ? prev_entry : new_entry;
    end else if (ctl.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* design/two_key_sorted_priority_queue.sv */
// Two-key sorted min-priority queue built as a chain of compare/shift cells.
// Timing: result valid in the cycle after the request is accepted.
// Throughput: one push or pop per cycle; a stalled result holds off requests.
// Reset: clears the entry count and the result valid; slot contents are left
// as they are and are never read before being written.
module two_key_sorted_priority_queue import tskpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

`include "two_key_sorted_priority_queue_defines.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic             accept;
  logic             is_full, is_empty;
  slot_ctl_t        ctl;
  entry_t           new_entry;
  entry_t           slot_q  [QUEUE_DEPTH];
  logic             shift_q [QUEUE_DEPTH];

  // a new request enters when the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign is_empty = count_r == '0;

  assign new_entry = '{pri: in_req.entry_priority, trt: in_req.entry_treatment,
                       tag: in_req.entry_id};
  assign ctl.push  = accept && (in_req.req_type == REQ_PUSH) && !is_full;
  assign ctl.pop   = accept && (in_req.req_type == REQ_POP) && !is_empty;

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_s;
    if (i == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_s = 1'b0;
    end else begin : g_mid
      assign prev_e = slot_q[i-1];
      assign prev_s = shift_q[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = slot_q[i];
    end else begin : g_inner
      assign next_e = slot_q[i+1];
    end
    tskpq_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_shift (prev_s),
      .next_entry (next_e),
      .entry      (slot_q[i]),
      .shift      (shift_q[i])
    );
  end

  // count, status and result valid
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STAT_OK;
      if (in_req.req_type == REQ_PUSH) begin
        if (is_full) status_nxt = STAT_FULL;
        else         count_nxt  = count_r + 1'b1;
      end else begin
        if (is_empty) status_nxt = STAT_EMPTY;
        else          count_nxt  = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
  end

  // result shows the state left by the last accepted request
  assign out_valid              = out_valid_r;
  assign out_rsp.head_valid     = !is_empty;
  assign out_rsp.head_priority  = is_empty ? '0 : slot_q[0].pri;
  assign out_rsp.head_treatment = is_empty ? '0 : slot_q[0].trt;
  assign out_rsp.head_id        = is_empty ? '0 : slot_q[0].tag;
  assign out_rsp.occupancy      = OCC_BITS'(count_r);
  assign out_rsp.status         = status_r;

  // checks
  `TSKPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "count over depth")
  `TSKPQ_ASSERT_ALWAYS(a_head_order,
    (count_r < CNT_W'(2)) || ({slot_q[0].pri, slot_q[0].trt} <= {slot_q[1].pri, slot_q[1].trt}),
    "head not smallest")
  `TSKPQ_ASSERT_NEXT(a_push_grows, ctl.push, count_r == $past(count_r) + 1'b1, "push lost")
  `TSKPQ_ASSERT_NEXT(a_pop_shrinks, ctl.pop, count_r == $past(count_r) - 1'b1, "pop lost")
  `TSKPQ_ASSERT_NEXT(a_reject_full, accept && is_full && (in_req.req_type == REQ_PUSH),
    (status_r == STAT_FULL) && $stable(count_r), "full push not rejected")

endmodule

/* tb/tb_two_key_sorted_priority_queue.sv */
// Self-checking testbench for the two-key sorted priority queue: a directed table, then
// random push/pop traffic with random idling, checked against a sorted-list predictor.
// Depends on tskpq_pkg and two_key_sorted_priority_queue.
`timescale 1ns / 100ps

module tb_two_key_sorted_priority_queue;
  import tskpq_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_WAIT  = 5;
  localparam int RAND_BLOCKS = 45;
  localparam int BLOCK_LEN   = 30;

  // one directed row: request, plus an optional typed-in response
  typedef struct packed {
    in_req_t  req;
    logic     known;
    out_rsp_t rsp;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_rsp;

  // sideband carried with each request: typed-in response, if any
  logic     note_known;
  out_rsp_t note_rsp;

  // shared idling controls
  bit no_gaps;
  bit hold_request;

  // predictor state: sorted entries and fill count
  entry_t   held_entries [DEPTH_DEF];
  int       held_count;
  out_rsp_t rsp_expected [$];
  int       fail_count;
  int       idle_cycles;

  two_key_sorted_priority_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // apply one request to the sorted list and return the head/count/status after it
  function automatic out_rsp_t queue_step(input in_req_t r);
    out_rsp_t rsp;
    entry_t   ent;
    int       pos;
    int       i;
    rsp = '0;
    rsp.status = STAT_OK;
    if (r.req_type == REQ_PUSH) begin
      if (held_count >= DEPTH_DEF) begin
        rsp.status = STAT_FULL;
      end else begin
        ent.pri = r.entry_priority;
        ent.trt = r.entry_treatment;
        ent.tag = r.entry_id;
        // first slot with a strictly larger key; equal keys stay ahead
        pos = held_count;
        for (i = 0; i < held_count; i++) begin
          if (pos == held_count &&
              {held_entries[i].pri, held_entries[i].trt} > {ent.pri, ent.trt}) begin
            pos = i;
          end
        end
        for (i = held_count; i > pos; i--) held_entries[i] = held_entries[i-1];
        held_entries[pos] = ent;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        rsp.status = STAT_EMPTY;
      end else begin
        for (i = 0; i + 1 < held_count; i++) held_entries[i] = held_entries[i+1];
        held_count--;
      end
    end
    if (held_count > 0) begin
      rsp.head_valid     = 1'b1;
      rsp.head_priority  = held_entries[0].pri;
      rsp.head_treatment = held_entries[0].trt;
      rsp.head_id        = held_entries[0].tag;
    end
    rsp.occupancy = held_count[OCC_BITS-1:0];
    return rsp;
  endfunction

  function automatic void field_check(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic stim_row_t req_row(input logic op, input logic [PRI_BITS-1:0] pri,
                                        input logic [TRT_BITS-1:0] trt,
                                        input logic [TAG_BITS-1:0] id);
    stim_row_t row;
    row = '0;
    row.req.req_type        = op;
    row.req.entry_priority  = pri;
    row.req.entry_treatment = trt;
    row.req.entry_id        = id;
    return row;
  endfunction

  function automatic stim_row_t known_row(input stim_row_t row, input logic hv,
                                          input logic [PRI_BITS-1:0] hp,
                                          input logic [TRT_BITS-1:0] ht,
                                          input logic [TAG_BITS-1:0] hid,
                                          input logic [OCC_BITS-1:0] occ,
                                          input status_t st);
    stim_row_t r;
    r = row;
    r.known              = 1'b1;
    r.rsp.head_valid     = hv;
    r.rsp.head_priority  = hp;
    r.rsp.head_treatment = ht;
    r.rsp.head_id        = hid;
    r.rsp.occupancy      = occ;
    r.rsp.status         = st;
    return r;
  endfunction

  // offer one request after a random gap, hold it until accepted
  task automatic send_request(input in_req_t req, input logic known, input out_rsp_t rsp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_req     <= req;
    note_known <= known;
    note_rsp   <= rsp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // prediction on accepted requests, comparison on accepted responses
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rsp_expected.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          want = rsp_expected.pop_front();
          field_check("head_valid", want.head_valid, out_rsp.head_valid);
          field_check("head_priority", want.head_priority, out_rsp.head_priority);
          field_check("head_treatment", want.head_treatment, out_rsp.head_treatment);
          field_check("head_id", want.head_id, out_rsp.head_id);
          field_check("occupancy", want.occupancy, out_rsp.occupancy);
          field_check("status", want.status, out_rsp.status);
        end
      end
      if (in_valid && !in_stall) begin
        want = queue_step(in_req);
        rsp_expected.push_back(note_known ? note_rsp : want);
      end
    end
  end

  // response side: random stall before each response, one long hold on demand
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // watchdog: cycles with no request or response moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_key_sorted_priority_queue test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_table [$];
    in_req_t   req;
    int        push_pct;
    bit        narrow;
    int        blk;
    int        k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    note_known   = 1'b0;
    note_rsp     = '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    held_count   = 0;
    fail_count   = 0;
    idle_cycles  = 0;

    // empty pop, key extremes, ties in both orders, fill to full, push into full, pops with a push between
    dir_table.push_back(known_row(req_row(REQ_POP, 8'h00, 16'h0000, 16'h0000),
                                  1'b0, 8'h00, 16'h0000, 16'h0000, 5'd0, STAT_EMPTY));
    dir_table.push_back(known_row(req_row(REQ_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF),
                                  1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd1, STAT_OK));
    dir_table.push_back(known_row(req_row(REQ_PUSH, 8'h00, 16'h0000, 16'h0000),
                                  1'b1, 8'h00, 16'h0000, 16'h0000, 5'd2, STAT_OK));
    dir_table.push_back(known_row(req_row(REQ_PUSH, 8'h00, 16'h0000, 16'h0001),
                                  1'b1, 8'h00, 16'h0000, 16'h0000, 5'd3, STAT_OK));
    dir_table.push_back(req_row(REQ_PUSH, 8'hFF, 16'hFFFF, 16'h0002));
    dir_table.push_back(req_row(REQ_PUSH, 8'h00, 16'hFFFF, 16'h0003));
    dir_table.push_back(req_row(REQ_PUSH, 8'hFF, 16'h0000, 16'h0004));
    dir_table.push_back(req_row(REQ_PUSH, 8'h80, 16'h8000, 16'h0005));
    dir_table.push_back(req_row(REQ_PUSH, 8'h7F, 16'h7FFF, 16'h0006));
    dir_table.push_back(req_row(REQ_PUSH, 8'h80, 16'h7FFF, 16'h0007));
    dir_table.push_back(req_row(REQ_PUSH, 8'h01, 16'h0001, 16'h0008));
    dir_table.push_back(req_row(REQ_PUSH, 8'hFE, 16'hFFFE, 16'h0009));
    dir_table.push_back(req_row(REQ_PUSH, 8'h80, 16'h8000, 16'h000A));
    dir_table.push_back(req_row(REQ_PUSH, 8'h55, 16'hAAAA, 16'h000B));
    dir_table.push_back(req_row(REQ_PUSH, 8'hAA, 16'h5555, 16'h000C));
    dir_table.push_back(req_row(REQ_PUSH, 8'h00, 16'h0000, 16'h000D));
    dir_table.push_back(req_row(REQ_PUSH, 8'h33, 16'h3333, 16'h000E));
    dir_table.push_back(known_row(req_row(REQ_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF),
                                  1'b1, 8'h00, 16'h0000, 16'h0000, 5'd16, STAT_FULL));
    dir_table.push_back(req_row(REQ_POP, 8'hFF, 16'hFFFF, 16'hFFFF));
    dir_table.push_back(req_row(REQ_POP, 8'h00, 16'h0000, 16'h0000));
    dir_table.push_back(req_row(REQ_POP, 8'h5A, 16'hA5A5, 16'h5A5A));
    dir_table.push_back(req_row(REQ_PUSH, 8'h00, 16'h0000, 16'hFFFF));
    dir_table.push_back(req_row(REQ_POP, 8'h00, 16'h0000, 16'h0000));
    dir_table.push_back(req_row(REQ_POP, 8'h00, 16'h0000, 16'h0000));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) send_request(dir_table[i].req, dir_table[i].known,
                                        dir_table[i].rsp);

    // random blocks of push-heavy, pop-heavy or balanced traffic, so the
    // queue swings between full and empty; narrow keys force ties
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      narrow  = 1'($urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 4) == 0);
      if (blk == 10) begin
        // long response hold while requests keep coming
        no_gaps      = 1'b1;
        push_pct     = 60;
        hold_request = 1'b1;
      end
      if (blk == 20) begin
        // sender pause until every response is back
        @(negedge clk);
        in_valid <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge clk);
      end
      for (k = 0; k < BLOCK_LEN; k++) begin
        req.req_type        = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
        req.entry_priority  = narrow ? PRI_BITS'($urandom_range(0, 3))
                                     : PRI_BITS'($urandom_range(0, 255));
        req.entry_treatment = narrow ? TRT_BITS'($urandom_range(0, 3))
                                     : TRT_BITS'($urandom_range(0, 65535));
        req.entry_id        = TAG_BITS'($urandom_range(0, 65535));
        send_request(req, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && rsp_expected.size() == 0) begin
      $display("two_key_sorted_priority_queue test passed");
    end else begin
      $display("two_key_sorted_priority_queue test failed");
    end
    $finish;
  end

endmodule
